@@ rtl/bdq_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bounded deque: transaction structs, operation and status codes,
// and the command and status groups between controller and datapath. No dependencies.
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_COUNT      = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] match_count;
      logic [4:0] size;
   } rsp_type;

   typedef struct packed {
      logic do_op;        // apply a push, pop or unused code and load its result
      logic start_scan;   // latch the compare word and restart the scan
      logic scan_read;    // read the next stored word of the scan
      logic finish_scan;  // load the count result
   } cmd_type;

   typedef struct packed {
      logic scan_left;    // stored words remain to be read
      logic rd_pending;   // a read issued last cycle is being compared
      logic rsp_free;     // the result register can take a new result this cycle
   } stat_type;

endpackage

@@ rtl/bounded_deque_with_match_count.sv @@
`timescale 1ns / 1ps
// Top level of the bounded deque with match count: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dpath.
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_data (func, value); one
//   result per request leaves on rsp_valid / rsp_stall / rsp_data (status,
//   match_count, size). A transaction completes on a clock edge with valid
//   high and stall low.
//   Push, pop and unused codes are applied in the cycle of acceptance and
//   the result is registered, so it appears in the next cycle; one request
//   per cycle while no count scan or stalled result holds the input. A count
//   request walks the stored words from the front, one memory read per
//   cycle, through the single read port of the word store, and the block
//   accepts nothing else until the count result is loaded.
//   The result register frees as its transaction completes, so a new request
//   is taken in the same cycle the previous result is taken.
//   While rsp_stall is high with a result waiting, req_stall stays high.
//   Reset (synchronous, active high) empties the queue: front pointer and
//   element count go to zero; the stored words are not cleared.
module bounded_deque_with_match_count #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bdq_pkg::rsp_type rsp_data
);

   bdq_pkg::cmd_type  cmd;
   bdq_pkg::stat_type stat;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ rtl/bdq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the bounded deque: accepts requests and sequences the count scan.
// Depends on bdq_pkg for codes and the command and status structs.
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_func,
   output logic              req_stall,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE) || !stat.rsp_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == bdq_pkg::OP_COUNT) begin
                  cmd.start_scan = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.do_op = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_read = stat.scan_left;
            if (!stat.scan_left && !stat.rd_pending) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish_scan = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bdq_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the bounded deque: word ring memory, front pointer, element count,
// scan counters, match counter and the result register. Depends on bdq_pkg.
module bdq_dpath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  bdq_pkg::req_type  req_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output bdq_pkg::rsp_type  rsp_data,
   input  bdq_pkg::cmd_type  cmd,
   output bdq_pkg::stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_POS  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);

   logic signed [31:0] slots [DEPTH];
   logic signed [31:0] rd_word_ff;

   logic [PW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic [CW-1:0]      match_ff, match_in;
   logic               rd_valid_ff;
   logic signed [31:0] value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type   rsp_ff, rsp_in;

   logic               we;
   logic [PW-1:0]      wa;
   logic [1:0]         op_status;
   logic               full;
   logic               empty;
   logic [PW-1:0]      front_dec;
   logic [PW-1:0]      front_inc;
   logic [CW:0]        back_sum;
   logic [CW:0]        back_wrap;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST_POS : front_ff - PW'(1);
   assign front_inc = (front_ff == LAST_POS) ? '0 : front_ff + PW'(1);
   assign back_sum  = (CW + 1)'(front_ff) + (CW + 1)'(count_ff);
   assign back_wrap = (back_sum >= DEPTH_SUM) ? back_sum - DEPTH_SUM : back_sum;

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      we        = 1'b0;
      wa        = front_ff;
      op_status = bdq_pkg::ST_OK;
      if (cmd.do_op) begin
         case (req_data.func)
            bdq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  op_status = bdq_pkg::ST_FULL;
               end else begin
                  we       = 1'b1;
                  wa       = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  op_status = bdq_pkg::ST_FULL;
               end else begin
                  we       = 1'b1;
                  wa       = back_wrap[PW-1:0];
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  op_status = bdq_pkg::ST_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            bdq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  op_status = bdq_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The scan walks from the front pointer, one stored word per cycle.
   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      scan_idx_in = scan_idx_ff;
      match_in    = match_ff;
      if (cmd.start_scan) begin
         scan_ptr_in = front_ff;
         scan_idx_in = '0;
         match_in    = '0;
      end else begin
         if (cmd.scan_read) begin
            scan_ptr_in = (scan_ptr_ff == LAST_POS) ? '0 : scan_ptr_ff + PW'(1);
            scan_idx_in = scan_idx_ff + CW'(1);
         end
         if (rd_valid_ff && (rd_word_ff == value_ff)) begin
            match_in = match_ff + CW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.do_op) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = op_status;
         rsp_in.match_count = '0;
         rsp_in.size        = 5'(count_in);
      end else if (cmd.finish_scan) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = bdq_pkg::ST_OK;
         rsp_in.match_count = 5'(match_ff);
         rsp_in.size        = 5'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slots[wa] <= req_data.value;
      end
      if (cmd.scan_read) begin
         rd_word_ff <= slots[scan_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      match_ff    <= match_in;
      rsp_ff      <= rsp_in;
      if (cmd.start_scan) begin
         value_ff <= req_data.value;
      end
   end

   assign stat.scan_left  = (scan_idx_ff < count_ff);
   assign stat.rd_pending = rd_valid_ff;
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
